### src/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int ACT_W    = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 3;
    localparam int LEN_W    = 6;
    localparam int CMP_W    = POS_W + 1;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_AT    = 3'd5,
        ACT_DISPLAY   = 3'd6,
        ACT_NONE      = 3'd7
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_APPENDED = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    typedef struct packed {
        logic load_cmd;
        logic exec_edit;
        logic emit_item;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic disp_items;
        logic idx_last;
    } ctl_stat_t;

endpackage

### src/ple_ctrl.sv
`timescale 1ns / 1ps

module ple_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ple_pkg::ctl_stat_t stat,
    output ple_pkg::ctl_cmd_t  cmd
);
    import ple_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load_cmd  = 1'b0;
        cmd.exec_edit = 1'b0;
        cmd.emit_item = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_cmd = 1'b1;
                    state_next   = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (stat.out_free)
                begin
                    // A display of a non-empty list stays here for one beat per element.
                    if (stat.disp_items)
                    begin
                        cmd.emit_item = 1'b1;
                        if (stat.idx_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.exec_edit = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/ple_datapath.sv
`timescale 1ns / 1ps

module ple_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ple_pkg::ctl_cmd_t            cmd,
    output ple_pkg::ctl_stat_t           stat,
    input  logic [ple_pkg::ACT_W-1:0]    in_action,
    input  logic [ple_pkg::VAL_W-1:0]    in_value,
    input  logic [ple_pkg::POS_W-1:0]    in_position,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ple_pkg::STAT_W-1:0]   out_status,
    output logic [ple_pkg::LEN_W-1:0]    out_length,
    output logic [ple_pkg::VAL_W-1:0]    out_value,
    output logic                         out_is_item,
    output logic                         out_last
);
    import ple_pkg::*;

    logic [VAL_W-1:0]  store_reg [CAPACITY];
    logic [VAL_W-1:0]  store_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ACT_W-1:0]  action_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [POS_W-1:0]  position_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [VAL_W-1:0]  item_reg;
    logic              is_item_reg;
    logic              last_reg;

    logic [STAT_W-1:0] edit_status;
    logic              do_ins;
    logic              do_del;
    logic [IDX_W-1:0]  edit_idx;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              is_full;
    logic              is_empty;

    assign pos_ext  = CMP_W'(position_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Decode the held command into an insert or delete at one index and its result status.
    always_comb
    begin
        edit_status = ST_OK;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        edit_idx    = '0;
        case (action_reg)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
            begin
                if (is_full)
                begin
                    edit_status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    if (action_reg == ACT_INS_FRONT)
                    begin
                        edit_idx = '0;
                    end
                    else if (action_reg == ACT_INS_BACK)
                    begin
                        edit_idx = IDX_W'(count_reg);
                    end
                    else if (pos_ext <= CMP_W'(1))
                    begin
                        edit_idx = '0;
                    end
                    else if (pos_ext <= cnt_ext + CMP_W'(1))
                    begin
                        edit_idx = IDX_W'(pos_ext - CMP_W'(1));
                    end
                    else
                    begin
                        edit_idx    = IDX_W'(count_reg);
                        edit_status = ST_APPENDED;
                    end
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT:
            begin
                if (is_empty)
                begin
                    edit_status = ST_EMPTY;
                end
                else if (action_reg == ACT_DEL_FRONT)
                begin
                    do_del   = 1'b1;
                    edit_idx = '0;
                end
                else if (action_reg == ACT_DEL_BACK)
                begin
                    do_del   = 1'b1;
                    edit_idx = IDX_W'(count_reg - CNT_W'(1));
                end
                else if ((pos_ext >= CMP_W'(1)) && (pos_ext <= cnt_ext))
                begin
                    do_del   = 1'b1;
                    edit_idx = IDX_W'(pos_ext - CMP_W'(1));
                end
                else
                begin
                    edit_status = ST_RANGE;
                end
            end
            ACT_DISPLAY:
            begin
                // Only reached here for an empty list.
                edit_status = ST_EMPTY;
            end
            default:
            begin
                edit_status = ST_OK;
            end
        endcase
    end

    // Every cell picks its neighbor, the new value or itself.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            store_next[i] = store_reg[i];
            if (do_ins)
            begin
                if (IDX_W'(i) == edit_idx)
                begin
                    store_next[i] = value_reg;
                end
                else if ((i > 0) && (IDX_W'(i) > edit_idx))
                begin
                    store_next[i] = store_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_del)
            begin
                if ((i < CAPACITY - 1) && (IDX_W'(i) >= edit_idx))
                begin
                    store_next[i] = store_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_edit)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
        if (cmd.load_cmd)
        begin
            action_reg   <= in_action;
            value_reg    <= in_value;
            position_reg <= in_position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec_edit)
            begin
                count_reg <= count_next;
            end
            if (cmd.load_cmd)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit_item)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.exec_edit || cmd.emit_item)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_edit)
        begin
            status_reg  <= edit_status;
            length_reg  <= LEN_W'(count_next);
            item_reg    <= '0;
            is_item_reg <= 1'b0;
            last_reg    <= 1'b1;
        end
        else if (cmd.emit_item)
        begin
            status_reg  <= ST_OK;
            length_reg  <= LEN_W'(count_reg);
            item_reg    <= store_reg[idx_reg];
            is_item_reg <= 1'b1;
            last_reg    <= stat.idx_last;
        end
    end

    assign stat.out_free   = !valid_reg || out_ready;
    assign stat.disp_items = (action_reg == ACT_DISPLAY) && !is_empty;
    assign stat.idx_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign out_valid   = valid_reg;
    assign out_status  = status_reg;
    assign out_length  = length_reg;
    assign out_value   = item_reg;
    assign out_is_item = is_item_reg;
    assign out_last    = last_reg;

endmodule

### src/positional_list_engine_unit.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values, one command per input beat.
// The slave channel carries action, value and position in s_tdata. Each command
// gives one result beat on the master channel; a display of a non-empty list
// gives one beat per element, front to back, with m_tuser set and m_tlast on the
// final element.
// An accepted command is held in a register while the controller executes it. When
// the output register is free, the controller loads the first result beat into it,
// raising m_tvalid, and then each further displayed element in turn. Edits shift
// every cell of the register store together.
// The output register is refilled in the cycle the receiver takes a beat, so a
// display streams at one beat per cycle while m_tready stays high.
// When the receiver stalls, the result beat holds and the controller waits; a
// new command is not taken until the current one has finished.
// Reset clears the element count and the output valid; the element storage is
// not cleared and is only read below the count.
module positional_list_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // action[2:0], value[34:3], position[42:35], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[2:0], length_after[8:3], item_value[40:9], zero fill
    output logic        m_tuser,   // is_item
    output logic        m_tlast
);
    import ple_pkg::*;

    ctl_cmd_t          cmd;
    ctl_stat_t         stat;
    logic [STAT_W-1:0] out_status;
    logic [LEN_W-1:0]  out_length;
    logic [VAL_W-1:0]  out_value;

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ple_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_action   (s_tdata[ACT_W-1:0]),
        .in_value    (s_tdata[ACT_W+VAL_W-1:ACT_W]),
        .in_position (s_tdata[ACT_W+VAL_W+POS_W-1:ACT_W+VAL_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_length  (out_length),
        .out_value   (out_value),
        .out_is_item (m_tuser),
        .out_last    (m_tlast)
    );

    assign m_tdata = {{(OUT_W - STAT_W - LEN_W - VAL_W){1'b0}}, out_value, out_length, out_status};

endmodule

### bench/positional_list_engine_unit_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_unit_tb;
    import ple_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_ITEMS  = 120;

    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] length_after;
        logic [VAL_W-1:0] item_value;
        logic             is_item;
        logic             last;
    } list_beat_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;    // action[2:0], value[34:3], position[42:35], zero fill
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // status[2:0], length_after[8:3], item_value[40:9], zero fill
    logic             m_tuser;          // is_item
    logic             m_tlast;

    list_beat_t       expected_beats[$];
    logic [VAL_W-1:0] list_contents[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    bit hold_start    = 1'b0;
    bit grow_mode     = 1'b1;

    positional_list_engine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("positional_list_engine_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic string beat_text(input list_beat_t b);
        return $sformatf("status=%0d length=%0d value=%h item=%b last=%b",
                         b.status, b.length_after, b.item_value, b.is_item, b.last);
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < REPORT_LIMIT)
            $display("ERROR: %s", msg);
        fail_count++;
    endtask

    task automatic push_beat(input status_t st, input logic [VAL_W-1:0] val,
                             input logic is_item, input logic last);
        list_beat_t b;
        b.status       = st;
        b.length_after = LEN_W'(list_contents.size());
        b.item_value   = val;
        b.is_item      = is_item;
        b.last         = last;
        expected_beats.push_back(b);
    endtask

    // Applies one accepted command to the list copy and queues the beats it yields.
    task automatic predict_list_command(input action_t act, input logic [VAL_W-1:0] val,
                                        input logic [POS_W-1:0] pos);
        int      count;
        status_t st;
        count = list_contents.size();
        st    = ST_OK;
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
            begin
                if (count >= CAPACITY)
                    st = ST_FULL;
                else if (act == ACT_INS_FRONT)
                    list_contents.push_front(val);
                else if (act == ACT_INS_BACK)
                    list_contents.push_back(val);
                else if (pos <= 1)
                    list_contents.push_front(val);
                else if (int'(pos) <= count + 1)
                    list_contents.insert(int'(pos) - 1, val);
                else
                begin
                    list_contents.push_back(val);
                    st = ST_APPENDED;
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT:
            begin
                if (count == 0)
                    st = ST_EMPTY;
                else if (act == ACT_DEL_FRONT)
                    void'(list_contents.pop_front());
                else if (act == ACT_DEL_BACK)
                    void'(list_contents.pop_back());
                else if (pos >= 1 && int'(pos) <= count)
                    list_contents.delete(int'(pos) - 1);
                else
                    st = ST_RANGE;
            end
            ACT_DISPLAY:
            begin
                if (count == 0)
                    push_beat(ST_EMPTY, '0, 1'b0, 1'b1);
                for (int i = 0; i < count; i++)
                    push_beat(ST_OK, list_contents[i], 1'b1, i == count - 1);
                return;
            end
            default:
                st = ST_OK;
        endcase
        push_beat(st, '0, 1'b0, 1'b1);
    endtask

    // Offers one command beat, waits for the handshake and records the prediction.
    task automatic send_command(input action_t act, input logic [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - POS_W - VAL_W - ACT_W){1'b0}}, pos, val, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_list_command(act, val, pos);
    endtask

    // Mostly well-formed edits that sweep the length between empty and full.
    task automatic pick_random_command(output action_t act, output logic [VAL_W-1:0] val,
                                       output logic [POS_W-1:0] pos);
        int len;
        int roll;
        len = list_contents.size();
        if (len >= CAPACITY)
            grow_mode = 1'b0;
        else if (len == 0)
            grow_mode = 1'b1;
        else if ($urandom_range(99) < 3)
            grow_mode = ~grow_mode;
        roll = $urandom_range(99);
        val  = $urandom;
        if ($urandom_range(99) < 80)
            pos = POS_W'($urandom_range(len + 2, 0));
        else
            pos = POS_W'($urandom_range(255, 0));
        if (roll < 4)
            act = ACT_DISPLAY;
        else if (roll < 6)
            act = ACT_NONE;
        else if (roll < 10)
            act = action_t'($urandom_range(7, 0));
        else if (roll < (grow_mode ? 70 : 35))
            act = action_t'($urandom_range(ACT_INS_AT, ACT_INS_FRONT));
        else
            act = action_t'($urandom_range(ACT_DEL_AT, ACT_DEL_FRONT));
    endtask

    task automatic test_empty_list();
        send_command(ACT_DISPLAY,   32'h0000_0000, 8'd0);
        send_command(ACT_DEL_FRONT, 32'h0000_0000, 8'd0);
        send_command(ACT_DEL_BACK,  32'h0000_0000, 8'd0);
        send_command(ACT_DEL_AT,    32'h0000_0000, 8'd1);
        send_command(ACT_NONE,      32'hFFFF_FFFF, 8'hFF);
    endtask

    task automatic test_insert_positions();
        send_command(ACT_INS_FRONT, 32'h8000_0000, 8'd0);
        send_command(ACT_INS_BACK,  32'h7FFF_FFFF, 8'd0);
        send_command(ACT_INS_AT,    32'h0000_0001, 8'd0);
        send_command(ACT_INS_AT,    32'h0000_0002, 8'd1);
        // Position one past the end appends without complaint.
        send_command(ACT_INS_AT,    32'h0000_0003, 8'd5);
        send_command(ACT_INS_AT,    32'hFFFF_FFFF, 8'd255);
        send_command(ACT_INS_AT,    32'h0000_0000, 8'd3);
        send_command(ACT_DISPLAY,   32'h0000_0000, 8'd0);
    endtask

    task automatic test_delete_positions();
        send_command(ACT_DEL_AT,    32'h0000_0000, 8'd0);
        send_command(ACT_DEL_AT,    32'h0000_0000, 8'd255);
        send_command(ACT_DEL_AT,    32'h0000_0000, 8'd8);
        send_command(ACT_DEL_AT,    32'h0000_0000, 8'd2);
        send_command(ACT_DEL_AT,    32'h0000_0000, 8'd6);
        send_command(ACT_DEL_FRONT, 32'h0000_0000, 8'd0);
        send_command(ACT_DEL_BACK,  32'h0000_0000, 8'd0);
        send_command(ACT_NONE,      32'h0000_0000, 8'd0);
        send_command(ACT_DISPLAY,   32'h0000_0000, 8'd0);
    endtask

    task automatic test_full_list();
        while (list_contents.size() < CAPACITY)
            send_command(action_t'($urandom_range(ACT_INS_AT, ACT_INS_FRONT)), $urandom,
                         POS_W'($urandom_range(list_contents.size() + 2, 0)));
        // A full list drops every insert, even one with a bad position.
        send_command(ACT_INS_FRONT, $urandom, 8'd0);
        send_command(ACT_INS_BACK,  $urandom, 8'd0);
        send_command(ACT_INS_AT,    $urandom, 8'd255);
        send_command(ACT_DISPLAY,   32'h0000_0000, 8'd0);
        send_command(ACT_DEL_AT,    32'h0000_0000, POS_W'(CAPACITY));
        send_command(ACT_DEL_AT,    32'h0000_0000, POS_W'(CAPACITY));
        send_command(ACT_INS_AT,    $urandom, POS_W'(CAPACITY));
    endtask

    // The receiver stops for a long stretch while commands keep coming.
    task automatic test_backpressure();
        action_t          act;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        hold_start = 1'b1;
        send_command(ACT_DISPLAY, 32'h0000_0000, 8'd0);
        repeat (12)
        begin
            pick_random_command(act, val, pos);
            send_command(act, val, pos);
        end
    endtask

    task automatic test_random_mix(input int count);
        action_t          act;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        repeat (count)
        begin
            pick_random_command(act, val, pos);
            send_command(act, val, pos);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        list_beat_t want;
        list_beat_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status       = status_t'(m_tdata[2:0]);
            got.length_after = m_tdata[8:3];
            got.item_value   = m_tdata[40:9];
            got.is_item      = m_tuser;
            got.last         = m_tlast;
            if (expected_beats.size() == 0)
                note_failure($sformatf("unexpected result beat: %s", beat_text(got)));
            else
            begin
                want = expected_beats.pop_front();
                if (got.status !== want.status || got.length_after !== want.length_after ||
                    got.item_value !== want.item_value || got.is_item !== want.is_item ||
                    got.last !== want.last)
                    note_failure($sformatf("result mismatch: expected %s, got %s",
                                           beat_text(want), beat_text(got)));
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 70;
        test_empty_list();
        test_insert_positions();
        test_delete_positions();
        test_full_list();
        test_random_mix(RANDOM_ITEMS);

        send_idle_pct = 70;
        recv_idle_pct = 12;
        test_backpressure();
        test_random_mix(RANDOM_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(RANDOM_ITEMS);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
            note_failure($sformatf("%0d expected beats never arrived", expected_beats.size()));

        if (fail_count == 0)
            $display("positional_list_engine_unit_tb OK");
        else
            $display("positional_list_engine_unit_tb NOT OK");
        $finish;
    end

endmodule
